// ----- rtl/nmea_sentence_validator_top_macros.svh -----
// Assertion macros for the NMEA sentence validator checker.
// Used only by the checker file; depends on nothing else.
`ifndef NMEA_SENTENCE_VALIDATOR_TOP_MACROS_SVH
`define NMEA_SENTENCE_VALIDATOR_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define NSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define NSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/nsv_pkg.sv -----
// Types and constants shared by the NMEA sentence validator modules.
// No dependencies.
package nsv_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       valid_res;
    logic [3:0] error_code;
    logic [6:0] field_count;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [6:0]  max_field_len;
    logic [5:0]  max_fields;
  } cfg_regs_t;

  // Configuration register indexes.
  localparam int          CFG_IDX_W        = 2;
  localparam int          CFG_DATA_W       = 16;
  localparam logic [1:0]  REG_TIMEOUT_MS   = 2'd0;
  localparam logic [1:0]  REG_MAX_FIELD_LEN = 2'd1;
  localparam logic [1:0]  REG_MAX_FIELDS   = 2'd2;

  localparam logic [15:0] TIMEOUT_RST      = 16'd1000;
  localparam logic [6:0]  MAX_FIELD_LEN_RST = 7'd20;
  localparam logic [5:0]  MAX_FIELDS_RST   = 6'd30;

  // Verdict codes.
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_TIMEOUT   = 4'd1;
  localparam logic [3:0] ERR_TAG_FRAME = 4'd2;
  localparam logic [3:0] ERR_TAG_LEN   = 4'd3;
  localparam logic [3:0] ERR_TAG_FMT   = 4'd4;
  localparam logic [3:0] ERR_TAG_CSUM  = 4'd5;
  localparam logic [3:0] ERR_NO_DOLLAR = 4'd6;
  localparam logic [3:0] ERR_CSUM      = 4'd7;
  localparam logic [3:0] ERR_BAD_CHAR  = 4'd8;
  localparam logic [3:0] ERR_FIELD     = 4'd9;

  // One flag for each check, indexed by its verdict code.
  typedef logic [9:2] err_flags_t;

  // Characters the parser looks for.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_PR_LO  = 8'h20;
  localparam logic [7:0] CH_PR_HI  = 8'h7E;

  localparam logic [6:0]  SAT7        = 7'h7F;
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  typedef enum logic [9:0] {
    PH_START      = 10'b00_0000_0001,
    PH_TAG_BODY   = 10'b00_0000_0010,
    PH_TAG_HEX    = 10'b00_0000_0100,
    PH_TAG_TAIL   = 10'b00_0000_1000,
    PH_SENT_FIRST = 10'b00_0001_0000,
    PH_SENT_BODY  = 10'b00_0010_0000,
    PH_SENT_HEX   = 10'b00_0100_0000,
    PH_SENT_TAIL  = 10'b00_1000_0000,
    PH_SKIP       = 10'b01_0000_0000,
    PH_ENDED      = 10'b10_0000_0000
  } phase_t;

  // Bit 4 set means the byte is not a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b0, b[3:0]};
    if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
      return {1'b0, 4'(b[3:0] + 4'd9)};
    return 5'h10;
  endfunction

endpackage

// ----- rtl/nmea_sentence_validator_top.sv -----
// Top level of the NMEA 0183 sentence validator: configuration registers,
// the parser and the two-entry result buffer. Depends on nsv_pkg and nsv_parser.
//
//   Channel   Direction  Handshake             Payload
//   in_*      in         in_valid / in_stall   nsv_pkg::in_item_t  (op, data_byte)
//   out_*     out        out_valid / out_stall nsv_pkg::out_item_t (valid_res,
//                                              error_code, field_count)
//   cfg_*     in         cfg_we                cfg_index, cfg_wdata
//
// An item is accepted in every cycle in which the skid entry is empty and is
// parsed in that cycle; its verdict is registered into the result register,
// or the skid entry if the result register stalls; they hold up to two verdicts.
// in_stall is high only while the skid entry is full. Reset is synchronous and
// active low, and restores the register defaults and an empty message.
module nmea_sentence_validator_top #(
  parameter int MAX_MSG_LEN = 128,
  parameter int MAX_TAG_LEN = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nsv_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nsv_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [nsv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  nsv_pkg::cfg_regs_t cfg_r;
  nsv_pkg::result_t   res;
  nsv_pkg::out_item_t out_data_r, skid_data_r;
  logic               out_valid_r, skid_valid_r;
  logic               in_fire, out_take;

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms    <= nsv_pkg::TIMEOUT_RST;
      cfg_r.max_field_len <= nsv_pkg::MAX_FIELD_LEN_RST;
      cfg_r.max_fields    <= nsv_pkg::MAX_FIELDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nsv_pkg::REG_TIMEOUT_MS:    cfg_r.timeout_ms    <= cfg_wdata;
        nsv_pkg::REG_MAX_FIELD_LEN: cfg_r.max_field_len <= cfg_wdata[6:0];
        nsv_pkg::REG_MAX_FIELDS:    cfg_r.max_fields    <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Input is taken whenever the skid entry has room for a possible verdict.
  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;

  nsv_parser #(
    .MAX_MSG_LEN(MAX_MSG_LEN),
    .MAX_TAG_LEN(MAX_TAG_LEN)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_item(in_item),
    .cfg    (cfg_r),
    .res    (res)
  );

  // Result register with one skid entry behind it. A new verdict goes to the
  // result register when it is empty or being drained, otherwise to the skid.
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res.valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_data_r <= skid_data_r;
    end else if (res.valid) begin
      if (!out_valid_r || out_take) out_data_r <= res.item;
      else skid_data_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

endmodule

// ----- rtl/nsv_parser.sv -----
// Message framing, streaming checks and verdict for the NMEA sentence validator.
// Depends on nsv_pkg.
module nsv_parser #(
  parameter int MAX_MSG_LEN = 128,
  parameter int MAX_TAG_LEN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  nsv_pkg::in_item_t in_item,
  input  nsv_pkg::cfg_regs_t cfg,
  output nsv_pkg::result_t  res
);

  localparam int IdxW = $clog2(MAX_MSG_LEN);
  localparam logic [IdxW-1:0] IDX_LAST = IdxW'(MAX_MSG_LEN - 1);
  localparam logic [6:0] TAG_LIMIT = 7'(MAX_TAG_LEN);

  nsv_pkg::phase_t     phase_r, phase_nxt;
  logic [IdxW-1:0]     byte_idx_r, byte_idx_nxt;
  logic [16:0]         elapsed_r, elapsed_nxt;
  logic [7:0]          tag_xor_r, tag_xor_nxt;
  logic [6:0]          tag_len_r, tag_len_nxt;
  logic [7:0]          sent_xor_r, sent_xor_nxt;
  logic [7:0]          hex_r, hex_nxt;
  logic [1:0]          hex_seen_r, hex_seen_nxt;
  logic [6:0]          field_len_r, field_len_nxt;
  logic [6:0]          fields_r, fields_nxt;
  nsv_pkg::err_flags_t flags_r, flags_nxt;

  always_comb begin
    logic [7:0]  b;
    logic        in_frame, msg_done, do_take, do_end;
    logic        tag_close, dig_tag, dig_sent, fchar;
    logic [4:0]  hv;
    logic [7:0]  expect_xor;
    logic [3:0]  dig_code, code;
    nsv_pkg::phase_t dig_next;

    b          = in_item.data_byte;
    in_frame   = byte_idx_r < IDX_LAST;
    msg_done   = !in_frame || (b == nsv_pkg::CH_LF);
    do_take    = in_frame && (phase_r != nsv_pkg::PH_ENDED) && (b != nsv_pkg::CH_NUL);
    tag_close  = 1'b0;
    dig_tag    = 1'b0;
    dig_sent   = 1'b0;
    fchar      = 1'b0;
    hv         = nsv_pkg::hex_of(b);
    expect_xor = '0;
    dig_code   = nsv_pkg::ERR_NONE;
    dig_next   = nsv_pkg::PH_TAG_TAIL;
    code       = nsv_pkg::ERR_NONE;

    phase_nxt     = phase_r;
    byte_idx_nxt  = byte_idx_r;
    elapsed_nxt   = elapsed_r;
    tag_xor_nxt   = tag_xor_r;
    tag_len_nxt   = tag_len_r;
    sent_xor_nxt  = sent_xor_r;
    hex_nxt       = hex_r;
    hex_seen_nxt  = hex_seen_r;
    field_len_nxt = field_len_r;
    fields_nxt    = fields_r;
    flags_nxt     = flags_r;

    // Per-byte parse step.
    if (do_take) begin
      if (phase_r inside {nsv_pkg::PH_TAG_BODY, nsv_pkg::PH_TAG_HEX, nsv_pkg::PH_TAG_TAIL}
          && tag_len_r != nsv_pkg::SAT7) begin
        tag_len_nxt = tag_len_r + 7'd1;
      end
      case (phase_r)
        nsv_pkg::PH_START, nsv_pkg::PH_SENT_FIRST: begin
          if (phase_r == nsv_pkg::PH_START && b == nsv_pkg::CH_BSL) begin
            phase_nxt   = nsv_pkg::PH_TAG_BODY;
            tag_len_nxt = 7'd1;
            tag_xor_nxt = '0;
          end else if (b == nsv_pkg::CH_DOLLAR) begin
            phase_nxt    = nsv_pkg::PH_SENT_BODY;
            sent_xor_nxt = '0;
          end else begin
            flags_nxt[nsv_pkg::ERR_NO_DOLLAR] = 1'b1;
            phase_nxt = nsv_pkg::PH_SKIP;
          end
        end
        nsv_pkg::PH_TAG_BODY: begin
          if (b == nsv_pkg::CH_BSL) begin
            flags_nxt[nsv_pkg::ERR_TAG_FMT] = 1'b1;
            tag_close = 1'b1;
          end else if (b == nsv_pkg::CH_STAR) begin
            phase_nxt    = nsv_pkg::PH_TAG_HEX;
            hex_nxt      = '0;
            hex_seen_nxt = '0;
          end else begin
            tag_xor_nxt = tag_xor_r ^ b;
          end
        end
        nsv_pkg::PH_TAG_HEX: begin
          if (b == nsv_pkg::CH_BSL) begin
            flags_nxt[nsv_pkg::ERR_TAG_FMT] = 1'b1;
            tag_close = 1'b1;
          end else begin
            dig_tag = 1'b1;
          end
        end
        nsv_pkg::PH_TAG_TAIL: begin
          tag_close = (b == nsv_pkg::CH_BSL);
        end
        nsv_pkg::PH_SENT_BODY: begin
          if (b == nsv_pkg::CH_STAR) begin
            phase_nxt    = nsv_pkg::PH_SENT_HEX;
            hex_nxt      = '0;
            hex_seen_nxt = '0;
          end else begin
            sent_xor_nxt = sent_xor_r ^ b;
            if (!(b inside {[nsv_pkg::CH_PR_LO:nsv_pkg::CH_PR_HI], nsv_pkg::CH_CR,
                            nsv_pkg::CH_LF})) begin
              flags_nxt[nsv_pkg::ERR_BAD_CHAR] = 1'b1;
            end
          end
          fchar = 1'b1;
        end
        nsv_pkg::PH_SENT_HEX: begin
          dig_sent = 1'b1;
          fchar    = 1'b1;
        end
        nsv_pkg::PH_SENT_TAIL: begin
          fchar = 1'b1;
        end
        default: begin
        end
      endcase

      // Checksum digit, shared by the TAG block and the sentence.
      if (dig_tag || dig_sent) begin
        expect_xor = dig_tag ? tag_xor_r : sent_xor_r;
        dig_code   = dig_tag ? nsv_pkg::ERR_TAG_CSUM : nsv_pkg::ERR_CSUM;
        dig_next   = dig_tag ? nsv_pkg::PH_TAG_TAIL : nsv_pkg::PH_SENT_TAIL;
        if (hv[4]) flags_nxt[dig_code] = 1'b1;
        else hex_nxt = {hex_r[3:0], hv[3:0]};
        hex_seen_nxt = hex_seen_r + 2'd1;
        if (hex_seen_r != 2'd0) begin
          if (hex_nxt != expect_xor) flags_nxt[dig_code] = 1'b1;
          phase_nxt = dig_next;
        end
      end

      if (tag_close) begin
        if (tag_len_nxt >= TAG_LIMIT) flags_nxt[nsv_pkg::ERR_TAG_LEN] = 1'b1;
        phase_nxt = (|flags_nxt) ? nsv_pkg::PH_SKIP : nsv_pkg::PH_SENT_FIRST;
      end

      if (fchar) begin
        if (b == nsv_pkg::CH_COMMA) begin
          if (field_len_r != 7'd0 && fields_r != nsv_pkg::SAT7) fields_nxt = fields_r + 7'd1;
          field_len_nxt = '0;
        end else begin
          if ({1'b0, field_len_r} + 8'd1 > {1'b0, cfg.max_field_len}) begin
            flags_nxt[nsv_pkg::ERR_FIELD] = 1'b1;
          end
          if (field_len_r != nsv_pkg::SAT7) field_len_nxt = field_len_r + 7'd1;
        end
      end
    end

    // End of content: a zero byte, a newline or a full frame.
    do_end = (in_frame && b == nsv_pkg::CH_NUL && phase_r != nsv_pkg::PH_ENDED)
          || (msg_done && phase_nxt != nsv_pkg::PH_ENDED);
    if (do_end) begin
      case (phase_nxt)
        nsv_pkg::PH_START, nsv_pkg::PH_SENT_FIRST: begin
          flags_nxt[nsv_pkg::ERR_NO_DOLLAR] = 1'b1;
        end
        nsv_pkg::PH_TAG_BODY, nsv_pkg::PH_TAG_HEX, nsv_pkg::PH_TAG_TAIL: begin
          flags_nxt[nsv_pkg::ERR_TAG_FRAME] = 1'b1;
        end
        nsv_pkg::PH_SENT_BODY, nsv_pkg::PH_SENT_HEX, nsv_pkg::PH_SENT_TAIL: begin
          if (phase_nxt != nsv_pkg::PH_SENT_TAIL) flags_nxt[nsv_pkg::ERR_CSUM] = 1'b1;
          if (field_len_nxt != 7'd0 && fields_nxt != nsv_pkg::SAT7) begin
            fields_nxt = fields_nxt + 7'd1;
          end
          field_len_nxt = '0;
          if (fields_nxt == 7'd0 || fields_nxt > {1'b0, cfg.max_fields}) begin
            flags_nxt[nsv_pkg::ERR_FIELD] = 1'b1;
          end
        end
        default: begin
        end
      endcase
      phase_nxt = nsv_pkg::PH_ENDED;
    end

    if (in_frame) byte_idx_nxt = byte_idx_r + 1'b1;

    // Verdict: timeout wins, then the lowest failed check.
    if (elapsed_r > {1'b0, cfg.timeout_ms}) begin
      code = nsv_pkg::ERR_TIMEOUT;
    end else begin
      for (int k = 9; k >= 2; k--) begin
        if (flags_nxt[k]) code = 4'(k);
      end
    end
    res.valid                = in_fire && !in_item.op && msg_done;
    res.item.valid_res       = (code == nsv_pkg::ERR_NONE);
    res.item.error_code      = code;
    res.item.field_count     = (code == nsv_pkg::ERR_NONE || code == nsv_pkg::ERR_FIELD)
                               ? fields_nxt : 7'd0;

    // A tick only advances the timer; a verdict starts a fresh message.
    if (in_item.op) begin
      phase_nxt     = phase_r;
      byte_idx_nxt  = byte_idx_r;
      tag_xor_nxt   = tag_xor_r;
      tag_len_nxt   = tag_len_r;
      sent_xor_nxt  = sent_xor_r;
      hex_nxt       = hex_r;
      hex_seen_nxt  = hex_seen_r;
      field_len_nxt = field_len_r;
      fields_nxt    = fields_r;
      flags_nxt     = flags_r;
      if (elapsed_r != nsv_pkg::ELAPSED_MAX) elapsed_nxt = elapsed_r + 17'd1;
    end else if (msg_done) begin
      phase_nxt     = nsv_pkg::PH_START;
      byte_idx_nxt  = '0;
      elapsed_nxt   = '0;
      tag_xor_nxt   = '0;
      tag_len_nxt   = '0;
      sent_xor_nxt  = '0;
      hex_nxt       = '0;
      hex_seen_nxt  = '0;
      field_len_nxt = '0;
      fields_nxt    = '0;
      flags_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= nsv_pkg::PH_START;
      byte_idx_r  <= '0;
      elapsed_r   <= '0;
      tag_xor_r   <= '0;
      tag_len_r   <= '0;
      sent_xor_r  <= '0;
      hex_r       <= '0;
      hex_seen_r  <= '0;
      field_len_r <= '0;
      fields_r    <= '0;
      flags_r     <= '0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      byte_idx_r  <= byte_idx_nxt;
      elapsed_r   <= elapsed_nxt;
      tag_xor_r   <= tag_xor_nxt;
      tag_len_r   <= tag_len_nxt;
      sent_xor_r  <= sent_xor_nxt;
      hex_r       <= hex_nxt;
      hex_seen_r  <= hex_seen_nxt;
      field_len_r <= field_len_nxt;
      fields_r    <= fields_nxt;
      flags_r     <= flags_nxt;
    end
  end

endmodule

// ----- rtl/nsv_checker.sv -----
// Port-level assertions for the NMEA sentence validator, bound to its top level.
// Depends on nsv_pkg and nmea_sentence_validator_top_macros.svh.
`include "nmea_sentence_validator_top_macros.svh"

module nsv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input nsv_pkg::out_item_t out_item
);

  // A stalled verdict stays in place.
  `NSV_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled verdict changed")

  // The pass bit agrees with the verdict code.
  `NSV_ASSERT_IMP(a_pass_bit, clk, rst_n, out_valid, out_item.valid_res == (out_item.error_code == nsv_pkg::ERR_NONE), "valid_res disagrees with error_code")

  // Only defined verdict codes are produced.
  `NSV_ASSERT_IMP(a_code_range, clk, rst_n, out_valid, out_item.error_code <= nsv_pkg::ERR_FIELD, "undefined error_code")

  // The field count is reported only on a pass or a field failure.
  `NSV_ASSERT_IMP(a_count_gate, clk, rst_n, out_valid && out_item.field_count != 7'd0, out_item.error_code == nsv_pkg::ERR_NONE || out_item.error_code == nsv_pkg::ERR_FIELD, "field_count on wrong verdict")

  // Input back-pressure only arises with a verdict already waiting.
  `NSV_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid, "input stalled with no pending verdict")

endmodule

bind nmea_sentence_validator_top nsv_checker u_nsv_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);

// ----- tb/nsv_tb_pkg.sv -----
// Verdict scoreboard for the NMEA sentence validator testbench: a bit-exact
// predictor of the message checks and the queue of verdicts still to arrive.
// Depends on nsv_pkg for the item types, verdict codes and parse phases.
package nsv_tb_pkg;
  import nsv_pkg::*;

  localparam int MSG_LEN_LIMIT = 128;
  localparam int TAG_LEN_LIMIT = 64;
  localparam int REPORT_LIMIT  = 10;

  class verdict_scoreboard;
    logic [15:0] timeout_lim;
    logic [6:0]  fld_len_lim;
    logic [5:0]  fld_cnt_lim;

    logic [16:0] elapsed;
    logic [7:0]  msg_pos;
    phase_t      phase;
    logic [7:0]  tag_sum;
    logic [6:0]  tag_len;
    logic [7:0]  body_sum;
    logic [7:0]  digit_acc;
    int          digit_cnt;
    logic [6:0]  cur_fld_len;
    logic [6:0]  fld_cnt;
    err_flags_t  flags;

    out_item_t   expected_verdicts[$];
    int          mismatches;

    function new();
      timeout_lim = TIMEOUT_RST;
      fld_len_lim = MAX_FIELD_LEN_RST;
      fld_cnt_lim = MAX_FIELDS_RST;
      elapsed     = '0;
      mismatches  = 0;
      clear_msg();
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_TIMEOUT_MS:    timeout_lim = val;
        REG_MAX_FIELD_LEN: fld_len_lim = val[6:0];
        REG_MAX_FIELDS:    fld_cnt_lim = val[5:0];
        default: ;
      endcase
    endfunction

    function void clear_msg();
      msg_pos     = '0;
      phase       = PH_START;
      tag_sum     = '0;
      tag_len     = '0;
      body_sum    = '0;
      digit_acc   = '0;
      digit_cnt   = 0;
      cur_fld_len = '0;
      fld_cnt     = '0;
      flags       = '0;
    endfunction

    // A digit that is not hex marks the checksum as wrong but still counts.
    function void take_digit(logic [7:0] b, logic [7:0] want, logic [3:0] code, phase_t nxt);
      int nib;
      nib = -1;
      if (b >= 8'h30 && b <= 8'h39) nib = b - 8'h30;
      else if (b >= 8'h41 && b <= 8'h46) nib = b - 8'h41 + 10;
      else if (b >= 8'h61 && b <= 8'h66) nib = b - 8'h61 + 10;
      if (nib < 0) flags[code] = 1'b1;
      else digit_acc = {digit_acc[3:0], 4'(nib)};
      digit_cnt++;
      if (digit_cnt >= 2) begin
        if (digit_acc != want) flags[code] = 1'b1;
        phase = nxt;
      end
    endfunction

    function void close_field();
      if (cur_fld_len > 0 && fld_cnt < SAT7) fld_cnt++;
      cur_fld_len = '0;
    endfunction

    function void field_char(logic [7:0] b);
      if (b == CH_COMMA) begin
        close_field();
        return;
      end
      if (int'(cur_fld_len) + 1 > int'(fld_len_lim)) flags[ERR_FIELD] = 1'b1;
      if (cur_fld_len < SAT7) cur_fld_len++;
    endfunction

    function void tag_close();
      if (tag_len >= TAG_LEN_LIMIT) flags[ERR_TAG_LEN] = 1'b1;
      phase = (flags != '0) ? PH_SKIP : PH_SENT_FIRST;
    endfunction

    function void sentence_first(logic [7:0] b);
      if (b == CH_DOLLAR) begin
        phase    = PH_SENT_BODY;
        body_sum = '0;
      end else begin
        flags[ERR_NO_DOLLAR] = 1'b1;
        phase = PH_SKIP;
      end
    endfunction

    function void end_content();
      case (phase)
        PH_START, PH_SENT_FIRST: flags[ERR_NO_DOLLAR] = 1'b1;
        PH_TAG_BODY, PH_TAG_HEX, PH_TAG_TAIL: flags[ERR_TAG_FRAME] = 1'b1;
        PH_SENT_BODY, PH_SENT_HEX, PH_SENT_TAIL: begin
          if (phase != PH_SENT_TAIL) flags[ERR_CSUM] = 1'b1;
          close_field();
          if (fld_cnt < 1 || fld_cnt > fld_cnt_lim) flags[ERR_FIELD] = 1'b1;
        end
        default: ;
      endcase
      phase = PH_ENDED;
    endfunction

    // Runs one accepted item through the predictor; a finished message
    // leaves its verdict in the queue.
    function void note_item(in_item_t it);
      logic [7:0] b;
      logic [3:0] code;
      out_item_t  v;
      if (it.op) begin
        if (elapsed < ELAPSED_MAX) elapsed++;
        return;
      end
      b = it.data_byte;
      if (msg_pos < MSG_LEN_LIMIT - 1) begin
        msg_pos++;
        if (phase != PH_ENDED) begin
          if (b == CH_NUL) begin
            end_content();
          end else begin
            if (phase inside {PH_TAG_BODY, PH_TAG_HEX, PH_TAG_TAIL} && tag_len < SAT7)
              tag_len++;
            case (phase)
              PH_START: begin
                if (b == CH_BSL) begin
                  phase   = PH_TAG_BODY;
                  tag_len = 7'd1;
                  tag_sum = '0;
                end else begin
                  sentence_first(b);
                end
              end
              PH_TAG_BODY: begin
                if (b == CH_BSL) begin
                  flags[ERR_TAG_FMT] = 1'b1;
                  tag_close();
                end else if (b == CH_STAR) begin
                  phase     = PH_TAG_HEX;
                  digit_acc = '0;
                  digit_cnt = 0;
                end else begin
                  tag_sum ^= b;
                end
              end
              PH_TAG_HEX: begin
                if (b == CH_BSL) begin
                  flags[ERR_TAG_FMT] = 1'b1;
                  tag_close();
                end else begin
                  take_digit(b, tag_sum, ERR_TAG_CSUM, PH_TAG_TAIL);
                end
              end
              PH_TAG_TAIL: begin
                if (b == CH_BSL) tag_close();
              end
              PH_SENT_FIRST: sentence_first(b);
              PH_SENT_BODY: begin
                if (b == CH_STAR) begin
                  phase     = PH_SENT_HEX;
                  digit_acc = '0;
                  digit_cnt = 0;
                end else begin
                  body_sum ^= b;
                  if (!((b >= CH_PR_LO && b <= CH_PR_HI) || b == CH_CR || b == CH_LF))
                    flags[ERR_BAD_CHAR] = 1'b1;
                end
                field_char(b);
              end
              PH_SENT_HEX: begin
                take_digit(b, body_sum, ERR_CSUM, PH_SENT_TAIL);
                field_char(b);
              end
              PH_SENT_TAIL: field_char(b);
              default: ;
            endcase
          end
        end
        if (b != CH_LF) return;
      end
      if (phase != PH_ENDED) end_content();

      code = ERR_NONE;
      if (elapsed > timeout_lim) begin
        code = ERR_TIMEOUT;
      end else begin
        for (int k = 9; k >= 2; k--)
          if (flags[k]) code = 4'(k);
      end
      v.valid_res   = (code == ERR_NONE);
      v.error_code  = code;
      v.field_count = (code == ERR_NONE || code == ERR_FIELD) ? fld_cnt : '0;
      expected_verdicts.push_back(v);
      elapsed = '0;
      clear_msg();
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void check_field(string name, int want, int got);
      if (want != got) flag_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t want;
      if (expected_verdicts.size() == 0) begin
        flag_mismatch($sformatf("verdict with none pending: valid_res %0d code %0d count %0d",
                                got.valid_res, got.error_code, got.field_count));
        return;
      end
      want = expected_verdicts.pop_front();
      check_field("valid_res", want.valid_res, got.valid_res);
      check_field("error_code", want.error_code, got.error_code);
      check_field("field_count", want.field_count, got.field_count);
    endfunction

    function int outstanding();
      return expected_verdicts.size();
    endfunction

    function void close_out();
      out_item_t want;
      while (expected_verdicts.size() != 0) begin
        want = expected_verdicts.pop_front();
        flag_mismatch($sformatf("verdict never arrived: code %0d count %0d",
                                want.error_code, want.field_count));
      end
    endfunction

    function int failures();
      return mismatches;
    endfunction
  endclass

endpackage

// ----- tb/tb_nmea_sentence_validator_top.sv -----
// Testbench for nmea_sentence_validator_top: drives bytes and millisecond ticks,
// predicts every verdict and checks it field by field with random idling.
// Depends on nsv_pkg and on the verdict scoreboard in nsv_tb_pkg.
module tb_nmea_sentence_validator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nsv_pkg::*;
  import nsv_tb_pkg::*;

  // Cycles without any handshake before the run is declared hung. The
  // longest legal quiet stretch is a handful of register writes or the
  // settling pause, so this leaves a wide margin over random stalls.
  localparam int QUIET_LIMIT   = 2000;
  // Verdicts are registered after the closing byte is taken; this pads the settling pause.
  localparam int SETTLE_CYCLES = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  verdict_scoreboard verdicts;

  // Messages are assembled as bytes in line_q, then moved into item_q with
  // random ticks mixed in, and finally driven one item at a time.
  logic [7:0] line_q[$];
  in_item_t   item_q[$];

  int src_idle_pct;
  int sink_stall_pct;
  int tick_pct;
  int quiet_cycles;

  nmea_sentence_validator_top #(
    .MAX_MSG_LEN(MSG_LEN_LIMIT),
    .MAX_TAG_LEN(TAG_LEN_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver decides at every falling edge whether to hold off results.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Both handshakes are sampled at the rising edge. A verdict accepted now
  // always belongs to an item accepted at an earlier edge, so it is checked
  // before the incoming item is fed to the predictor. The same block keeps
  // the watchdog that ends a run in which nothing moves any more.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) verdicts.check_verdict(out_item);
      if (in_valid && !in_stall) verdicts.note_item(in_item);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n - 4'd10);
  endfunction

  // Printable character other than the two that would change the framing.
  function automatic logic [7:0] pick_char(logic [7:0] skip_a, logic [7:0] skip_b);
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (c == skip_a || c == skip_b);
    return c;
  endfunction

  // Appends '*' and the two checksum digits, in upper or lower case at random.
  function automatic void append_sum(logic [7:0] sum);
    bit lower;
    lower = 1'($urandom);
    line_q.push_back(CH_STAR);
    line_q.push_back(hex_char(sum[7:4], lower));
    line_q.push_back(hex_char(sum[3:0], lower));
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  // A correct sentence around the given body, for the directed cases.
  function automatic void push_sentence(string body);
    logic [7:0] sum;
    sum = '0;
    line_q.push_back(CH_DOLLAR);
    for (int i = 0; i < body.len(); i++) begin
      line_q.push_back(body[i]);
      sum ^= body[i];
    end
    append_sum(sum);
    line_q.push_back(CH_LF);
  endfunction

  // Moves the assembled bytes into the item queue, with ticks sprinkled in.
  function automatic void push_line();
    in_item_t it;
    foreach (line_q[i]) begin
      while ($urandom_range(0, 99) < tick_pct) begin
        it.op        = 1'b1;
        it.data_byte = 8'($urandom);
        item_q.push_back(it);
      end
      it.op        = 1'b0;
      it.data_byte = line_q[i];
      item_q.push_back(it);
    end
    line_q.delete();
  endfunction

  function automatic void push_ticks(int n);
    in_item_t it;
    push_line();
    repeat (n) begin
      it.op        = 1'b1;
      it.data_byte = 8'($urandom);
      item_q.push_back(it);
    end
  endfunction

  // A TAG block with n body characters and a correct checksum.
  function automatic void build_tag(int n);
    logic [7:0] sum;
    logic [7:0] c;
    sum = '0;
    line_q.push_back(CH_BSL);
    repeat (n) begin
      c = pick_char(CH_BSL, CH_STAR);
      sum ^= c;
      line_q.push_back(c);
    end
    append_sum(sum);
    line_q.push_back(CH_BSL);
  endfunction

  // A well-formed sentence with random fields of up to max_len characters.
  function automatic void build_sentence(int nfields, int max_len);
    logic [7:0] sum;
    logic [7:0] c;
    sum = '0;
    line_q.push_back(CH_DOLLAR);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) begin
        line_q.push_back(CH_COMMA);
        sum ^= CH_COMMA;
      end
      repeat ($urandom_range(0, max_len)) begin
        c = pick_char(CH_COMMA, CH_STAR);
        sum ^= c;
        line_q.push_back(c);
      end
    end
    append_sum(sum);
    if ($urandom_range(0, 1) == 1) line_q.push_back(CH_CR);
    line_q.push_back(CH_LF);
  endfunction

  // Breaks a well-formed message in one place.
  function automatic void mutate();
    int pos;
    pos = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 5))
      0: line_q[pos] = 8'($urandom);
      1: line_q.delete(pos);
      2: line_q.insert(pos, 8'($urandom));
      3: line_q.insert(pos, CH_NUL);
      4: line_q.insert(pos, 8'($urandom_range(1, 31)));
      default: line_q[pos] ^= 8'(1 << $urandom_range(0, 7));
    endcase
  endfunction

  // Drives one item, idling beforehand at the sender's rate. Valid goes up
  // at a falling edge and the item stays put until a rising edge sees no stall.
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      in_valid          <= 1'b0;
      in_item.op        <= 1'($urandom);
      in_item.data_byte <= 8'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_queued();
    push_line();
    foreach (item_q[i]) send_item(item_q[i]);
    item_q.delete();
  endtask

  // Drops valid and waits until every predicted verdict has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    verdicts.write_reg(idx, val);
  endtask

  task automatic set_regs(logic [15:0] tmo, logic [15:0] fld_len, logic [15:0] fld_cnt);
    write_cfg(REG_TIMEOUT_MS, tmo);
    write_cfg(REG_MAX_FIELD_LEN, fld_len);
    write_cfg(REG_MAX_FIELDS, fld_cnt);
  endtask

  // Random traffic: mostly well-formed sentences (some with a TAG block and
  // some broken in one spot), plus messages aimed at the tag length, field
  // count, field length and frame length limits, and plain noise. Only bytes
  // count toward n_bytes; tick bursts come on top. The phase ends with a
  // newline so that no message is left half parsed across a register change.
  task automatic random_phase(int n_bytes, int burst_max);
    int sent;
    int kind;
    sent     = 0;
    tick_pct = 2;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 5) == 0) push_ticks($urandom_range(1, burst_max));
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        if ($urandom_range(0, 2) == 0) build_tag($urandom_range(0, 8));
        build_sentence($urandom_range(1, 6), 8);
        if ($urandom_range(0, 3) == 0) mutate();
      end else if (kind < 60) begin
        build_tag($urandom_range(55, 64));
        build_sentence(1, 3);
      end else if (kind < 68) begin
        build_sentence($urandom_range(20, 70), 1);
      end else if (kind < 76) begin
        build_sentence($urandom_range(1, 3), 45);
      end else if (kind < 88) begin
        if ($urandom_range(0, 1) == 1) build_tag($urandom_range(0, 6));
        build_sentence($urandom_range(1, 5), 6);
        mutate();
        mutate();
      end else begin
        repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) line_q.push_back(CH_LF);
      end
      sent += line_q.size();
      send_queued();
    end
    line_q.push_back(CH_LF);
    send_queued();
    settle();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_TIMEOUT_MS;
    cfg_wdata      = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    tick_pct       = 0;
    quiet_cycles   = 0;
    verdicts       = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed cases with small limits: timeout 2 ms, fields up to 8
    // characters, at most 3 nonempty fields.
    set_regs(16'd2, 16'd8, 16'd3);
    push_sentence("A");                 // shortest valid sentence
    push_ticks(3);
    push_sentence("A");                 // one tick too many: timeout
    push_ticks(2);
    push_sentence("A");                 // exactly at the timeout: still valid
    push_text("\\ab*03\\$A*41\r\n");    // valid TAG block and CR
    push_text("\\ab*03$A*41\n");        // TAG block never closed
    push_text("\\ab\\$A*41\n");         // TAG block without a star
    push_text("\\ab*0\\$A*41\n");       // one digit after the TAG star
    push_text("\\ab*04\\$A*41\n");      // wrong TAG checksum
    push_text("\\ab*0g\\$A*41\n");      // non-hex TAG checksum digit
    push_text("A*41\n");                // no dollar sign
    push_text("\n");                    // empty message
    push_text("$A*4g\n");               // non-hex sentence checksum digit
    push_text("$A\n");                  // no star at all
    push_text("$A");                    // control character in the body
    line_q.push_back(8'h01);
    push_text("*40\n");
    push_text("$");                     // byte above the printable range
    line_q.push_back(8'h80);
    push_text("*80\n");
    push_sentence(" ");                 // lowest printable character
    push_sentence("~");                 // highest printable character
    push_sentence("ABCDEFGHI");         // field one character too long
    push_sentence("A,B,C,D");           // one field too many
    push_sentence(",,");                // only the checksum tail is a field
    push_text("$A*41");                 // zero byte ends the content early
    line_q.push_back(CH_NUL);
    push_text("xyz\n");
    line_q.push_back(CH_NUL);           // zero byte as the first byte
    line_q.push_back(CH_LF);
    line_q.push_back(CH_DOLLAR);        // frame cut at the length limit
    repeat (140) line_q.push_back(8'h61);
    line_q.push_back(CH_LF);
    send_queued();
    settle();

    // Sender idles less than the receiver, with the widest limits.
    src_idle_pct   = 29;
    sink_stall_pct = 52;
    set_regs(16'hFFFF, 16'd127, 16'd63);
    random_phase(420, 20);

    // Roles swapped: the tightest limits, including out-of-range zeros.
    src_idle_pct   = 52;
    sink_stall_pct = 29;
    set_regs(16'd0, 16'd1, 16'd1);
    random_phase(120, 3);
    set_regs(16'd5, 16'd0, 16'd0);
    random_phase(80, 8);
    set_regs(16'd40, 16'd12, 16'd8);
    random_phase(250, 60);

    // No idling on either side, back at the reset limits.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_regs(TIMEOUT_RST, 16'(MAX_FIELD_LEN_RST), 16'(MAX_FIELDS_RST));
    random_phase(300, 1100);

    // The elapsed counter must saturate rather than wrap, and a count equal
    // to the largest timeout must still pass.
    set_regs(16'hFFFF, 16'd20, 16'd30);
    push_ticks(131080);
    push_sentence("GPGGA,1");
    push_ticks(65535);
    push_sentence("GPGGA,2");
    send_queued();
    settle();

    verdicts.close_out();
    if (verdicts.failures() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
